@@ rtl/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared widths, register indexes, config and divider structs and saturation helper
// for the particle to plane collision block.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int NUM_PLANES = 4;
  localparam int ACC_W      = 66;
  localparam int DIV_DW     = 50;
  localparam int DIV_QW     = 31;
  localparam int DIV_CELLS  = DIV_QW;
  localparam int IN_W       = 256;
  localparam int OUT_W      = 224;
  localparam int USER_W     = 3;
  localparam int APB_AW     = 6;
  localparam int APB_DW     = 64;

  localparam logic [2:0] REG_PLANE_A = 3'd0;
  localparam logic [2:0] REG_PLANE_B = 3'd1;
  localparam logic [2:0] REG_PLANE_C = 3'd2;
  localparam logic [2:0] REG_PLANE_D = 3'd3;
  localparam logic [2:0] REG_COUNT   = 3'd4;
  localparam logic [2:0] REG_RADIUS  = 3'd5;
  localparam logic [2:0] REG_BOUNCE  = 3'd6;
  localparam logic [2:0] REG_LOSS    = 3'd7;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 66'sh7FFFFFFF;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -66'sh80000000;

  typedef struct packed {
    logic [NUM_PLANES-1:0][63:0] plane;
    logic [2:0]                  plane_count;
    logic [30:0]                 radius;
    logic [31:0]                 bounce;
    logic [16:0]                 loss;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    logic [DIV_DW-1:0] rem;
    logic [DIV_DW-1:0] dvs;
    logic [DIV_QW-1:0] num;
    logic [DIV_QW-1:0] quo;
  } div_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) r = 32'sh7FFFFFFF;
    else if (x < SAT_MIN) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

@@ rtl/ppc_div_cell.sv @@
// ----------------------------------------------------------------------------
// ppc_div_cell
// One restoring division step: shifts in a numerator bit, trial subtract,
// registers remainder and quotient for the next cell.
// ----------------------------------------------------------------------------
module ppc_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppc_pkg::div_t stage_i,
  output ppc_pkg::div_t stage_o
);
  import ppc_pkg::*;

  logic              vld_q;
  logic [DIV_DW-1:0] rem_q, rem_d, dvs_q;
  logic [DIV_QW-1:0] num_q, quo_q;
  logic [DIV_DW:0]   trial, sub;
  logic              ge;

  assign trial = {stage_i.rem, stage_i.num[DIV_QW-1]};
  assign sub   = trial - {1'b0, stage_i.dvs};
  assign ge    = trial >= {1'b0, stage_i.dvs};
  assign rem_d = ge ? sub[DIV_DW-1:0] : trial[DIV_DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= stage_i.dvs;
    num_q <= {stage_i.num[DIV_QW-2:0], 1'b0};
    quo_q <= {stage_i.quo[DIV_QW-2:0], ge};
  end

  assign stage_o = '{vld: vld_q, rem: rem_q, dvs: dvs_q, num: num_q, quo: quo_q};

endmodule

@@ rtl/ppc_div_row.sv @@
// ----------------------------------------------------------------------------
// ppc_div_row
// Row of division cells, one quotient bit per cell, each cell handing its
// partial remainder to the next every cycle.
// ----------------------------------------------------------------------------
module ppc_div_row (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppc_pkg::div_t div_i,
  output ppc_pkg::div_t div_o
);
  import ppc_pkg::*;

  div_t link [0:DIV_CELLS];

  assign link[0] = div_i;

  for (genvar c = 0; c < DIV_CELLS; c++) begin : g_cell
    ppc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (link[c]),
      .stage_o (link[c+1])
    );
  end

  assign div_o = link[DIV_CELLS];

endmodule

@@ rtl/ppc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ppc_cfg_regs
// APB register file holding the planes, plane count, radius, bounce factors
// and lifetime loss.
// ----------------------------------------------------------------------------
module ppc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppc_pkg::APB_AW-1:0]  paddr,
  input  logic [ppc_pkg::APB_DW-1:0]  pwdata,
  output logic [ppc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output ppc_pkg::cfg_t               cfg_o
);
  import ppc_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_PLANE_A: cfg_q.plane[0]    <= pwdata;
        REG_PLANE_B: cfg_q.plane[1]    <= pwdata;
        REG_PLANE_C: cfg_q.plane[2]    <= pwdata;
        REG_PLANE_D: cfg_q.plane[3]    <= pwdata;
        REG_COUNT:   cfg_q.plane_count <= pwdata[2:0];
        REG_RADIUS:  cfg_q.radius      <= pwdata[30:0];
        REG_BOUNCE:  cfg_q.bounce      <= pwdata[31:0];
        REG_LOSS:    cfg_q.loss        <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PLANE_A: prdata = cfg_q.plane[0];
      REG_PLANE_B: prdata = cfg_q.plane[1];
      REG_PLANE_C: prdata = cfg_q.plane[2];
      REG_PLANE_D: prdata = cfg_q.plane[3];
      REG_COUNT:   prdata = {61'b0, cfg_q.plane_count};
      REG_RADIUS:  prdata = {33'b0, cfg_q.radius};
      REG_BOUNCE:  prdata = {32'b0, cfg_q.bounce};
      REG_LOSS:    prdata = {47'b0, cfg_q.loss};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/particle_plane_collision.sv @@
// ----------------------------------------------------------------------------
// particle_plane_collision
// Particle against up to four planes: finds the first plane hit, reflects
// and damps position and velocity, and charges the lifetime loss.
//
//   channel  | direction | transfer
//   s_axis   | in        | particle: pos, vel, life_left, life_initial
//   m_axis   | out       | new pos, new vel, new life; tuser collided, plane
//   apb      | in/out    | register writes and reads, pready always high
//
// One particle at a time, run by a micro-sequencer around one shared
// 40x18 multiplier and a 31-cell division row.
// Each plane is tested in turn; a hit then runs the division row and
// the two reflection passes on the multiplier.
// Result sits in an output register, so the next particle is taken while
// it waits. Reset clears control state, output valid and config registers; datapath registers are not reset.
// ----------------------------------------------------------------------------
module particle_plane_collision (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, life_initial
  input  logic [ppc_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, new_life
  output logic [ppc_pkg::OUT_W-1:0]    m_axis_tdata,
  // collided, plane_hit
  output logic [ppc_pkg::USER_W-1:0]   m_axis_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppc_pkg::APB_AW-1:0]   paddr,
  input  logic [ppc_pkg::APB_DW-1:0]   pwdata,
  output logic [ppc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import ppc_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DIST    = 4'd1;
  localparam logic [3:0] ST_VN      = 4'd2;
  localparam logic [3:0] ST_TEST    = 4'd3;
  localparam logic [3:0] ST_DIVIN   = 4'd4;
  localparam logic [3:0] ST_DIVWAIT = 4'd5;
  localparam logic [3:0] ST_DIFF    = 4'd6;
  localparam logic [3:0] ST_BD      = 4'd7;
  localparam logic [3:0] ST_BR      = 4'd8;
  localparam logic [3:0] ST_BC      = 4'd9;
  localparam logic [3:0] ST_BY      = 4'd10;
  localparam logic [3:0] ST_LIFE    = 4'd11;
  localparam logic [3:0] ST_FIN     = 4'd12;

  cfg_t cfg;
  div_t div_in, div_out;

  ppc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppc_div_row u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .div_i  (div_in),
    .div_o  (div_out)
  );

  // control
  logic [3:0] state_q, state_d;
  logic [2:0] k_q, k_d;
  logic [1:0] h_q, h_d, j_q, j_d;
  logic       xsel_q, xsel_d, got_q, got_d, ovld_q, ovld_d;
  logic       div_go, s_fire, out_ld;
  logic [1:0] ki;

  // datapath
  logic signed [31:0]       p_q [0:2];
  logic signed [31:0]       v_q [0:2];
  logic signed [31:0]       diff_q [0:2];
  logic signed [31:0]       r_q [0:2];
  logic signed [31:0]       nv_q [0:2];
  logic signed [41:0]       yp_q [0:2];
  logic [30:0]              life_q, init_q;
  logic [31:0]              life_new_q;
  logic signed [51:0]       dist_q;
  logic [DIV_DW-1:0]        g_q, uv_q;
  logic                     vneg_q, sat_q;
  logic signed [31:0]       t_q;
  logic signed [39:0]       w_q, e_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [OUT_W-1:0]         tdata_q;
  logic [USER_W-1:0]        tuser_q;

  // multiplier and accumulator
  logic signed [39:0]       mul_a;
  logic signed [17:0]       mul_b;
  logic signed [57:0]       prod;
  logic signed [ACC_W-1:0]  prod_x, acc_sr12, acc_sr13, acc_sr14;
  logic                     acc_ld, acc_clr, acc_sh;

  // plane and factors
  logic [63:0]              plane_w;
  logic signed [15:0]       nrm [0:2];
  logic signed [15:0]       off;
  logic [2:0]               limit;
  logic [44:0]              rad30;
  logic [15:0]              dfv;
  logic signed [17:0]       rfv;
  logic [16:0]              loss_c;
  logic signed [31:0]       xk;
  logic                     hit;
  logic signed [51:0]       g_s;
  logic signed [ACC_W-1:0]  vn_abs;
  logic [DIV_QW-1:0]        mag;
  logic signed [31:0]       t_new;
  logic signed [41:0]       y_new;
  logic signed [31:0]       np [0:2];

  assign ki      = k_q[1:0];
  assign plane_w = cfg.plane[j_q];
  assign nrm[0]  = $signed(plane_w[15:0]);
  assign nrm[1]  = $signed(plane_w[31:16]);
  assign nrm[2]  = $signed(plane_w[47:32]);
  assign off     = $signed(plane_w[63:48]);
  assign limit   = (cfg.plane_count > 3'd4) ? 3'd4 : cfg.plane_count;
  assign rad30   = {cfg.radius, 14'b0};
  assign dfv     = (cfg.bounce[15:0] > 16'd32768) ? 16'd0 : 16'd32768 - cfg.bounce[15:0];
  assign rfv     = 18'sd4096 - $signed({2'b0, cfg.bounce[31:16]});
  assign loss_c  = (cfg.loss > 17'd65536) ? 17'd65536 : cfg.loss;
  assign xk      = xsel_q ? v_q[ki] : diff_q[ki];

  assign prod     = mul_a * mul_b;
  assign prod_x   = ACC_W'(prod);
  assign acc_d    = (acc_clr ? ACC_W'(0) : acc_q) + (acc_sh ? (prod_x <<< 16) : prod_x);
  assign acc_sr12 = acc_q >>> 12;
  assign acc_sr13 = acc_q >>> 13;
  assign acc_sr14 = acc_q >>> 14;

  assign hit    = (dist_q <= $signed({7'b0, rad30})) && (acc_q != ACC_W'(0));
  assign g_s    = $signed({7'b0, rad30}) - dist_q;
  assign vn_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign mag    = sat_q ? {DIV_QW{1'b1}} : div_out.quo;
  assign t_new  = vneg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign y_new  = 42'(r_q[ki]) - $signed(acc_sr14[41:0]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      np[i] = sat32(ACC_W'(p_q[i]) - ACC_W'(diff_q[i]) + ACC_W'(yp_q[i]));
    end
  end

  assign div_in = '{vld: div_go,
                    rem: {15'b0, g_q[DIV_DW-1:15]},
                    dvs: uv_q,
                    num: {g_q[14:0], 16'b0},
                    quo: '0};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign out_ld        = (state_q == ST_FIN) && (!ovld_q || m_axis_tready);

  // operand selection
  always_comb begin
    acc_ld  = 1'b0;
    acc_clr = 1'b1;
    acc_sh  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      ST_DIST: if (k_q < 3'd3) begin
        acc_ld = 1'b1; acc_clr = (k_q == 3'd0);
        mul_a = 40'(p_q[ki]); mul_b = 18'(nrm[ki]);
      end
      ST_VN: begin
        acc_ld = 1'b1; acc_clr = (k_q == 3'd0);
        mul_a = 40'(v_q[ki]); mul_b = 18'(nrm[ki]);
      end
      ST_DIFF: begin
        mul_a = 40'(v_q[ki]);
        if (h_q == 2'd0) begin
          acc_ld = 1'b1; mul_b = $signed({2'b0, t_q[15:0]});
        end else if (h_q == 2'd1) begin
          acc_ld = 1'b1; acc_clr = 1'b0; acc_sh = 1'b1;
          mul_b = 18'($signed(t_q[31:16]));
        end
      end
      ST_BD: if (k_q < 3'd3) begin
        acc_ld = 1'b1; acc_clr = (k_q == 3'd0);
        mul_a = 40'(xk); mul_b = 18'(nrm[ki]);
      end
      ST_BR: begin
        if (h_q == 2'd0) begin
          acc_ld = 1'b1; mul_a = w_q; mul_b = 18'(nrm[ki]);
        end else if (h_q == 2'd2) begin
          acc_ld = 1'b1; mul_a = e_q; mul_b = $signed({2'b0, dfv});
        end
      end
      ST_BC: begin
        if (k_q < 3'd3) begin
          acc_ld = 1'b1; acc_clr = (k_q == 3'd0);
          mul_a = 40'(r_q[ki]); mul_b = 18'(nrm[ki]);
        end else if (k_q == 3'd4) begin
          acc_ld = 1'b1; mul_a = w_q; mul_b = rfv;
        end
      end
      ST_BY: if (h_q == 2'd0) begin
        acc_ld = 1'b1; mul_a = w_q; mul_b = 18'(nrm[ki]);
      end
      ST_LIFE: if (h_q == 2'd0) begin
        acc_ld = 1'b1;
        mul_a = $signed({9'b0, init_q}); mul_b = $signed({1'b0, loss_c});
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    h_d     = h_q;
    j_d     = j_q;
    xsel_d  = xsel_q;
    got_d   = got_q;
    ovld_d  = ovld_q;
    div_go  = 1'b0;
    if (m_axis_tvalid && m_axis_tready) ovld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (s_fire) begin
        j_d = 2'd0; k_d = 3'd0; h_d = 2'd0; got_d = 1'b0;
        state_d = (limit == 3'd0) ? ST_FIN : ST_DIST;
      end
      ST_DIST: begin
        if (k_q == 3'd3) begin
          k_d = 3'd0; state_d = ST_VN;
        end else k_d = k_q + 3'd1;
      end
      ST_VN: begin
        if (k_q == 3'd2) begin
          k_d = 3'd0; state_d = ST_TEST;
        end else k_d = k_q + 3'd1;
      end
      ST_TEST: begin
        if (hit) state_d = ST_DIVIN;
        else if (({1'b0, j_q} + 3'd1) == limit) state_d = ST_FIN;
        else begin
          j_d = j_q + 2'd1; state_d = ST_DIST;
        end
      end
      ST_DIVIN: begin
        div_go = 1'b1; state_d = ST_DIVWAIT;
      end
      ST_DIVWAIT: if (div_out.vld) begin
        k_d = 3'd0; h_d = 2'd0; state_d = ST_DIFF;
      end
      ST_DIFF: begin
        if (h_q == 2'd2) begin
          h_d = 2'd0;
          if (k_q == 3'd2) begin
            k_d = 3'd0; xsel_d = 1'b0; state_d = ST_BD;
          end else k_d = k_q + 3'd1;
        end else h_d = h_q + 2'd1;
      end
      ST_BD: begin
        if (k_q == 3'd3) begin
          k_d = 3'd0; h_d = 2'd0; state_d = ST_BR;
        end else k_d = k_q + 3'd1;
      end
      ST_BR: begin
        if (h_q == 2'd3) begin
          h_d = 2'd0;
          if (k_q == 3'd2) begin
            k_d = 3'd0; state_d = ST_BC;
          end else k_d = k_q + 3'd1;
        end else h_d = h_q + 2'd1;
      end
      ST_BC: begin
        if (k_q == 3'd5) begin
          k_d = 3'd0; h_d = 2'd0; state_d = ST_BY;
        end else k_d = k_q + 3'd1;
      end
      ST_BY: begin
        if (h_q == 2'd1) begin
          h_d = 2'd0;
          if (k_q == 3'd2) begin
            k_d = 3'd0;
            if (!xsel_q) begin
              xsel_d = 1'b1; state_d = ST_BD;
            end else state_d = ST_LIFE;
          end else k_d = k_q + 3'd1;
        end else h_d = h_q + 2'd1;
      end
      ST_LIFE: begin
        if (h_q == 2'd1) begin
          h_d = 2'd0; got_d = 1'b1; state_d = ST_FIN;
        end else h_d = h_q + 2'd1;
      end
      ST_FIN: if (out_ld) begin
        ovld_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      h_q     <= '0;
      j_q     <= '0;
      xsel_q  <= 1'b0;
      got_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      h_q     <= h_d;
      j_q     <= j_d;
      xsel_q  <= xsel_d;
      got_q   <= got_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_ld) acc_q <= acc_d;
    if (s_fire) begin
      p_q[0] <= $signed(s_axis_tdata[31:0]);
      p_q[1] <= $signed(s_axis_tdata[63:32]);
      p_q[2] <= $signed(s_axis_tdata[95:64]);
      v_q[0] <= $signed(s_axis_tdata[127:96]);
      v_q[1] <= $signed(s_axis_tdata[159:128]);
      v_q[2] <= $signed(s_axis_tdata[191:160]);
      life_q <= s_axis_tdata[222:192];
      init_q <= s_axis_tdata[253:223];
    end
    case (state_q)
      ST_DIST: if (k_q == 3'd3) dist_q <= 52'(acc_q - (ACC_W'(off) <<< 22));
      ST_TEST: begin
        g_q    <= g_s[DIV_DW-1:0];
        uv_q   <= vn_abs[DIV_DW-1:0];
        vneg_q <= acc_q[ACC_W-1];
      end
      ST_DIVIN: sat_q <= ({15'b0, g_q} >= {uv_q, 15'b0});
      ST_DIVWAIT: if (div_out.vld) t_q <= t_new;
      ST_DIFF: if (h_q == 2'd2) diff_q[ki] <= sat32((-acc_q) >>> 16);
      ST_BD: if (k_q == 3'd3) w_q <= $signed(acc_sr14[39:0]);
      ST_BR: begin
        if (h_q == 2'd1) e_q <= 40'(xk) - $signed(acc_sr13[39:0]);
        if (h_q == 2'd3) r_q[ki] <= sat32(acc_q >>> 15);
      end
      ST_BC: begin
        if (k_q == 3'd3) w_q <= $signed(acc_sr14[39:0]);
        if (k_q == 3'd5) w_q <= $signed(acc_sr12[39:0]);
      end
      ST_BY: if (h_q == 2'd1) begin
        if (!xsel_q) yp_q[ki] <= y_new;
        else nv_q[ki] <= sat32(ACC_W'(y_new));
      end
      ST_LIFE: if (h_q == 2'd1) life_new_q <= {1'b0, life_q} - acc_q[47:16];
      default: ;
    endcase
    if (out_ld) begin
      if (got_q) begin
        tdata_q <= {life_new_q, nv_q[2], nv_q[1], nv_q[0], np[2], np[1], np[0]};
        tuser_q <= {j_q, 1'b1};
      end else begin
        tdata_q <= {1'b0, life_q, v_q[2], v_q[1], v_q[0], p_q[2], p_q[1], p_q[0]};
        tuser_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule
